// ===== src/http_request_header_parser_unit_defines.svh =====
// Assertion macros for the HTTP request header parser.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef HTTP_REQUEST_HEADER_PARSER_UNIT_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define HRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition implies another one under non-overlapping implication.
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hrp_pkg.sv =====
// Types, character codes and lookup functions for the HTTP request header parser.
// No dependencies.
package hrp_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF   = 32;

  typedef enum logic [3:0] {
    PH_RL, PH_RL_CR, PH_RL_CRLF, PH_RL_CRLFCR, PH_KEY, PH_COLON, PH_SEP,
    PH_VAL, PH_VAL_CR, PH_VAL_CRLF, PH_VAL_CRLFCR, PH_BODY, PH_ERR
  } phase_e;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_DONE       = 2'd1,
    ST_ERROR      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    VP_SKIP, VP_DIGITS, VP_STOP
  } vphase_e;

  localparam logic [3:0] KEY_LEN   = 4'd14;
  localparam logic [1:0] SPACE_MAX = 2'd2;

  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_UC_A  = 8'h41;
  localparam logic [7:0] CHR_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // "content-length"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h6C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = (b >= CHR_UC_A && b <= CHR_UC_Z) ? b + CASE_DIFF : b;
    return r;
  endfunction

endpackage

// ===== src/http_request_header_parser_unit.sv =====
// HTTP request header parser: one request byte in, one annotated byte out.
// Each accepted byte's result word is registered in the output register.
// Throughput: one byte per cycle unless a waiting result is stalled by out_stall_i;
// each byte's transition and decimal accumulate step update the parser state registers.
// Reset: asynchronous, active low; parser returns to the request line state
// with all counters, flags and the latched length cleared, output empty.
`include "http_request_header_parser_unit_defines.svh"

module http_request_header_parser_unit #(
  parameter int POSITION_BITS = hrp_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = hrp_pkg::LENGTH_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     chunk_end_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               out_byte_o,
  output logic [1:0]               status_o,
  output logic [POSITION_BITS-1:0] position_o,
  output logic                     header_start_mark_o,
  output logic                     key_start_mark_o,
  output logic                     value_start_mark_o,
  output logic                     headers_end_mark_o,
  output logic [LENGTH_BITS-1:0]   content_length_o,
  output logic [POSITION_BITS-1:0] uri_start_o
);

  localparam int CMP_BITS = (POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS;

  hrp_pkg::phase_e             phase_q, phase_d;
  hrp_pkg::status_e            status_q, status_d;
  hrp_pkg::vphase_e            vphase_q, vphase_d;
  logic [POSITION_BITS-1:0]    byte_count_q, byte_count_d;
  logic [POSITION_BITS-1:0]    first_space_q, first_space_d;
  logic [POSITION_BITS-1:0]    body_start_q, body_start_d;
  logic [1:0]                  space_count_q, space_count_d;
  logic [3:0]                  key_pos_q, key_pos_d;
  logic                        key_mis_q, key_mis_d;
  logic                        len_found_q, len_found_d;
  logic                        vneg_q, vneg_d;
  logic [LENGTH_BITS-1:0]      vacc_q, vacc_d;
  logic [LENGTH_BITS-1:0]      length_q, length_d;

  logic                        out_valid_q;
  logic [7:0]                  out_byte_q;
  logic [POSITION_BITS-1:0]    position_q;
  logic                        hdr_mark_q, key_mark_q, val_mark_q, end_mark_q;
  logic [LENGTH_BITS-1:0]      clen_q;
  logic [POSITION_BITS-1:0]    uri_q;

  logic                        in_accept;
  logic [7:0]                  ob;
  logic                        m_hdr, m_key, m_val, m_end;
  logic                        kfeed, vfeed;
  logic [3:0]                  kpos_in;
  logic                        kmis_in;
  logic [7:0]                  kbyte;
  hrp_pkg::vphase_e            vph_in;
  logic                        vneg_in;
  logic [LENGTH_BITS-1:0]      vacc_in;
  logic                        is_ws, is_dig;
  logic [LENGTH_BITS+3:0]      acc_ext;
  logic [LENGTH_BITS-1:0]      acc_next;
  logic [POSITION_BITS-1:0]    got;
  logic [LENGTH_BITS-1:0]      need;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_ws  = (data_byte_i == hrp_pkg::CHR_SPACE) ||
                  (data_byte_i >= hrp_pkg::CHR_TAB && data_byte_i <= hrp_pkg::CHR_CR);
  assign is_dig = (data_byte_i >= hrp_pkg::CHR_ZERO) && (data_byte_i <= hrp_pkg::CHR_NINE);

  assign acc_ext  = ({4'b0, vacc_in} << 3) + ({4'b0, vacc_in} << 1) +
                    {{LENGTH_BITS{1'b0}}, data_byte_i[3:0]};
  assign acc_next = (|acc_ext[LENGTH_BITS+3:LENGTH_BITS]) ? {LENGTH_BITS{1'b1}}
                                                           : acc_ext[LENGTH_BITS-1:0];

  always_comb begin
    phase_d       = phase_q;
    status_d      = status_q;
    vphase_d      = vphase_q;
    byte_count_d  = byte_count_q;
    first_space_d = first_space_q;
    body_start_d  = body_start_q;
    space_count_d = space_count_q;
    key_pos_d     = key_pos_q;
    key_mis_d     = key_mis_q;
    len_found_d   = len_found_q;
    vneg_d        = vneg_q;
    vacc_d        = vacc_q;
    length_d      = length_q;
    ob            = data_byte_i;
    m_hdr         = 1'b0;
    m_key         = 1'b0;
    m_val         = 1'b0;
    m_end         = 1'b0;
    kfeed         = 1'b0;
    kpos_in       = key_pos_q;
    kmis_in       = key_mis_q;
    kbyte         = data_byte_i;
    vfeed         = 1'b0;
    vph_in        = vphase_q;
    vneg_in       = vneg_q;
    vacc_in       = vacc_q;
    got           = '0;
    need          = '0;

    if (status_q == hrp_pkg::ST_INCOMPLETE) begin
      if (data_byte_i == hrp_pkg::CHR_SPACE && space_count_q < hrp_pkg::SPACE_MAX) begin
        if (space_count_q == 2'd0) begin
          first_space_d = byte_count_q;
        end
        space_count_d = space_count_q + 2'd1;
      end

      phase_d = hrp_pkg::PH_ERR;
      case (phase_q)
        hrp_pkg::PH_RL: begin
          if (data_byte_i == hrp_pkg::CHR_CR) begin
            phase_d = hrp_pkg::PH_RL_CR;
            ob      = 8'h00;
          end else begin
            phase_d = hrp_pkg::PH_RL;
          end
        end
        hrp_pkg::PH_RL_CR, hrp_pkg::PH_VAL_CR: begin
          if (data_byte_i == hrp_pkg::CHR_LF) begin
            phase_d = (phase_q == hrp_pkg::PH_RL_CR) ? hrp_pkg::PH_RL_CRLF
                                                     : hrp_pkg::PH_VAL_CRLF;
          end
        end
        hrp_pkg::PH_RL_CRLF, hrp_pkg::PH_VAL_CRLF: begin
          if (data_byte_i == hrp_pkg::CHR_CR) begin
            phase_d = (phase_q == hrp_pkg::PH_RL_CRLF) ? hrp_pkg::PH_RL_CRLFCR
                                                       : hrp_pkg::PH_VAL_CRLFCR;
          end else begin
            phase_d = hrp_pkg::PH_KEY;
            ob      = hrp_pkg::to_lower(data_byte_i);
            m_hdr   = (phase_q == hrp_pkg::PH_RL_CRLF);
            m_key   = 1'b1;
            kfeed   = 1'b1;
            kpos_in = 4'd0;
            kmis_in = 1'b0;
          end
        end
        hrp_pkg::PH_RL_CRLFCR, hrp_pkg::PH_VAL_CRLFCR: begin
          if (data_byte_i == hrp_pkg::CHR_LF) begin
            phase_d      = hrp_pkg::PH_BODY;
            m_end        = 1'b1;
            body_start_d = byte_count_q + POSITION_BITS'(1);
          end
        end
        hrp_pkg::PH_KEY: begin
          if (data_byte_i == hrp_pkg::CHR_COLON) begin
            phase_d = hrp_pkg::PH_COLON;
            ob      = 8'h00;
          end else begin
            phase_d = hrp_pkg::PH_KEY;
            ob      = hrp_pkg::to_lower(data_byte_i);
            kfeed   = 1'b1;
          end
        end
        hrp_pkg::PH_COLON: begin
          if (data_byte_i == hrp_pkg::CHR_SPACE) begin
            phase_d = hrp_pkg::PH_SEP;
          end
        end
        hrp_pkg::PH_SEP: begin
          phase_d = hrp_pkg::PH_VAL;
          m_val   = 1'b1;
          vfeed   = 1'b1;
          vph_in  = hrp_pkg::VP_SKIP;
          vneg_in = 1'b0;
          vacc_in = '0;
        end
        hrp_pkg::PH_VAL: begin
          if (data_byte_i == hrp_pkg::CHR_CR) begin
            phase_d = hrp_pkg::PH_VAL_CR;
            ob      = 8'h00;
            if (!len_found_q && !key_mis_q && key_pos_q == hrp_pkg::KEY_LEN) begin
              len_found_d = 1'b1;
              length_d    = (vneg_q && vacc_q != '0) ? {LENGTH_BITS{1'b1}} : vacc_q;
            end
          end else begin
            phase_d = hrp_pkg::PH_VAL;
            vfeed   = 1'b1;
          end
        end
        hrp_pkg::PH_BODY: begin
          phase_d = hrp_pkg::PH_BODY;
        end
        default: begin
          phase_d = hrp_pkg::PH_ERR;
        end
      endcase

      byte_count_d = byte_count_q + POSITION_BITS'(1);

      if (kfeed) begin
        kbyte = ob;
        if (kmis_in || kpos_in >= hrp_pkg::KEY_LEN || kbyte != hrp_pkg::key_char(kpos_in)) begin
          key_mis_d = 1'b1;
          key_pos_d = kpos_in;
        end else begin
          key_mis_d = kmis_in;
          key_pos_d = kpos_in + 4'd1;
        end
      end

      if (vfeed) begin
        vphase_d = vph_in;
        vneg_d   = vneg_in;
        vacc_d   = vacc_in;
        case (vph_in)
          hrp_pkg::VP_SKIP: begin
            if (is_ws) begin
              vphase_d = hrp_pkg::VP_SKIP;
            end else if (data_byte_i == hrp_pkg::CHR_MINUS ||
                         data_byte_i == hrp_pkg::CHR_PLUS) begin
              vneg_d   = (data_byte_i == hrp_pkg::CHR_MINUS);
              vphase_d = hrp_pkg::VP_DIGITS;
            end else if (is_dig) begin
              vphase_d = hrp_pkg::VP_DIGITS;
              vacc_d   = acc_next;
            end else begin
              vphase_d = hrp_pkg::VP_STOP;
            end
          end
          hrp_pkg::VP_DIGITS: begin
            if (is_dig) begin
              vacc_d = acc_next;
            end else begin
              vphase_d = hrp_pkg::VP_STOP;
            end
          end
          default: begin
            vphase_d = hrp_pkg::VP_STOP;
          end
        endcase
      end

      got  = byte_count_d - body_start_d;
      need = len_found_d ? length_d : '0;
      if (chunk_end_i) begin
        if (phase_d == hrp_pkg::PH_ERR) begin
          status_d = hrp_pkg::ST_ERROR;
        end else if (phase_d == hrp_pkg::PH_BODY) begin
          if (need == '0 || CMP_BITS'(got) >= CMP_BITS'(need)) begin
            status_d = (space_count_d >= hrp_pkg::SPACE_MAX) ? hrp_pkg::ST_DONE
                                                             : hrp_pkg::ST_ERROR;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= hrp_pkg::PH_RL;
      status_q      <= hrp_pkg::ST_INCOMPLETE;
      vphase_q      <= hrp_pkg::VP_SKIP;
      byte_count_q  <= '0;
      first_space_q <= '0;
      body_start_q  <= '0;
      space_count_q <= '0;
      key_pos_q     <= '0;
      key_mis_q     <= 1'b0;
      len_found_q   <= 1'b0;
      vneg_q        <= 1'b0;
      vacc_q        <= '0;
      length_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        out_valid_q <= in_valid_i;
      end
      if (in_accept) begin
        phase_q       <= phase_d;
        status_q      <= status_d;
        vphase_q      <= vphase_d;
        byte_count_q  <= byte_count_d;
        first_space_q <= first_space_d;
        body_start_q  <= body_start_d;
        space_count_q <= space_count_d;
        key_pos_q     <= key_pos_d;
        key_mis_q     <= key_mis_d;
        len_found_q   <= len_found_d;
        vneg_q        <= vneg_d;
        vacc_q        <= vacc_d;
        length_q      <= length_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_byte_q <= ob;
      position_q <= byte_count_q;
      hdr_mark_q <= m_hdr;
      key_mark_q <= m_key;
      val_mark_q <= m_val;
      end_mark_q <= m_end;
      clen_q     <= (phase_d == hrp_pkg::PH_BODY && len_found_d) ? length_d : '0;
      uri_q      <= (status_d == hrp_pkg::ST_DONE) ? first_space_d + POSITION_BITS'(1) : '0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_byte_o          = out_byte_q;
  assign status_o            = status_q;
  assign position_o          = position_q;
  assign header_start_mark_o = hdr_mark_q;
  assign key_start_mark_o    = key_mark_q;
  assign value_start_mark_o  = val_mark_q;
  assign headers_end_mark_o  = end_mark_q;
  assign content_length_o    = clen_q;
  assign uri_start_o         = uri_q;

  `HRP_ASSERT_NEXT(a_status_sticky, status_q != hrp_pkg::ST_INCOMPLETE, status_q == $past(status_q), "status left a final value")
  `HRP_ASSERT(a_stall_blocks_input, (out_valid_q && out_stall_i) |-> in_stall_o, "input taken while result waits")
  `HRP_ASSERT(a_end_mark_body, (out_valid_q && end_mark_q) |-> (phase_q == hrp_pkg::PH_BODY), "headers end without body phase")
  `HRP_ASSERT_NEXT(a_count_advance, in_accept && status_q == hrp_pkg::ST_INCOMPLETE, byte_count_q == $past(byte_count_q) + POSITION_BITS'(1), "byte count did not advance")

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for http_request_header_parser_unit: drives one long request
// with random headers, a content-length body or a broken tail, and checks every word.
// Depends on hrp_pkg for phase, status and character codes.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT = 200000;
  localparam logic [31:0] LEN_MAX = '1;
  localparam logic [8*14-1:0] LENGTH_KEY = "content-length";

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [31:0] position;
    logic        header_start;
    logic        key_start;
    logic        value_start;
    logic        headers_end;
    logic [31:0] content_length;
    logic [31:0] uri_start;
  } parsed_byte_t;

  function automatic logic [7:0] key_char(int i);
    return LENGTH_KEY[8*(13-i) +: 8];
  endfunction

  class hdr_byte_checker;
    hrp_pkg::phase_e  phase;
    hrp_pkg::status_e status;
    hrp_pkg::vphase_e vphase;
    logic [31:0] byte_count, first_space_pos, value_accum, length_reg, body_start_pos;
    logic [1:0]  space_count;
    logic [3:0]  key_pos;
    logic        key_bad, length_found, value_neg;
    parsed_byte_t parsed_q[$];
    int          fails;
    int          words;

    function new();
      phase = hrp_pkg::PH_RL;
      status = hrp_pkg::ST_INCOMPLETE;
      vphase = hrp_pkg::VP_SKIP;
      byte_count = '0;
      first_space_pos = '0;
      value_accum = '0;
      length_reg = '0;
      body_start_pos = '0;
      space_count = '0;
      key_pos = '0;
      key_bad = 1'b0;
      length_found = 1'b0;
      value_neg = 1'b0;
      fails = 0;
      words = 0;
    endfunction

    function logic [7:0] lower(logic [7:0] b);
      if (b >= hrp_pkg::CHR_UC_A && b <= hrp_pkg::CHR_UC_Z) return b + 8'h20;
      return b;
    endfunction

    function void key_step(logic [7:0] b);
      if (key_bad || key_pos >= hrp_pkg::KEY_LEN || b != key_char(int'(key_pos))) key_bad = 1'b1;
      else key_pos = key_pos + 4'd1;
    endfunction

    function void digit_step(logic [7:0] b);
      logic        ws;
      logic        dig;
      logic [31:0] d;
      ws = (b == hrp_pkg::CHR_SPACE) || (b >= hrp_pkg::CHR_TAB && b <= hrp_pkg::CHR_CR);
      dig = (b >= hrp_pkg::CHR_ZERO && b <= hrp_pkg::CHR_NINE);
      if (vphase == hrp_pkg::VP_SKIP) begin
        if (ws) return;
        if (b == hrp_pkg::CHR_MINUS || b == hrp_pkg::CHR_PLUS) begin
          value_neg = (b == hrp_pkg::CHR_MINUS);
          vphase = hrp_pkg::VP_DIGITS;
          return;
        end
        if (!dig) begin
          vphase = hrp_pkg::VP_STOP;
          return;
        end
        vphase = hrp_pkg::VP_DIGITS;
      end else if (vphase != hrp_pkg::VP_DIGITS || !dig) begin
        vphase = hrp_pkg::VP_STOP;
        return;
      end
      d = {24'd0, b - hrp_pkg::CHR_ZERO};
      if (value_accum > (LEN_MAX - d) / 32'd10) value_accum = LEN_MAX;
      else value_accum = value_accum * 32'd10 + d;
    endfunction

    function void take_byte(logic [7:0] b, logic ce);
      parsed_byte_t    w;
      hrp_pkg::phase_e nx;
      logic [31:0]     pos;
      pos = byte_count;
      w = '0;
      w.out_byte = b;
      w.position = pos;
      if (status == hrp_pkg::ST_INCOMPLETE) begin
        nx = hrp_pkg::PH_ERR;
        if (b == hrp_pkg::CHR_SPACE && space_count < hrp_pkg::SPACE_MAX) begin
          if (space_count == 2'd0) first_space_pos = pos;
          space_count = space_count + 2'd1;
        end
        case (phase)
          hrp_pkg::PH_RL: begin
            if (b == hrp_pkg::CHR_CR) begin
              nx = hrp_pkg::PH_RL_CR;
              w.out_byte = 8'h00;
            end else begin
              nx = hrp_pkg::PH_RL;
            end
          end
          hrp_pkg::PH_RL_CR: if (b == hrp_pkg::CHR_LF) nx = hrp_pkg::PH_RL_CRLF;
          hrp_pkg::PH_RL_CRLF, hrp_pkg::PH_VAL_CRLF: begin
            if (b == hrp_pkg::CHR_CR) begin
              if (phase == hrp_pkg::PH_RL_CRLF) nx = hrp_pkg::PH_RL_CRLFCR;
              else nx = hrp_pkg::PH_VAL_CRLFCR;
            end else begin
              nx = hrp_pkg::PH_KEY;
              w.out_byte = lower(b);
              w.header_start = (phase == hrp_pkg::PH_RL_CRLF);
              w.key_start = 1'b1;
              key_pos = '0;
              key_bad = 1'b0;
              key_step(w.out_byte);
            end
          end
          hrp_pkg::PH_RL_CRLFCR, hrp_pkg::PH_VAL_CRLFCR: begin
            if (b == hrp_pkg::CHR_LF) begin
              nx = hrp_pkg::PH_BODY;
              w.headers_end = 1'b1;
              body_start_pos = pos + 32'd1;
            end
          end
          hrp_pkg::PH_KEY: begin
            if (b == hrp_pkg::CHR_COLON) begin
              nx = hrp_pkg::PH_COLON;
              w.out_byte = 8'h00;
            end else begin
              nx = hrp_pkg::PH_KEY;
              w.out_byte = lower(b);
              key_step(w.out_byte);
            end
          end
          hrp_pkg::PH_COLON: if (b == hrp_pkg::CHR_SPACE) nx = hrp_pkg::PH_SEP;
          hrp_pkg::PH_SEP: begin
            nx = hrp_pkg::PH_VAL;
            w.value_start = 1'b1;
            vphase = hrp_pkg::VP_SKIP;
            value_neg = 1'b0;
            value_accum = '0;
            digit_step(b);
          end
          hrp_pkg::PH_VAL: begin
            if (b == hrp_pkg::CHR_CR) begin
              nx = hrp_pkg::PH_VAL_CR;
              w.out_byte = 8'h00;
              if (!length_found && !key_bad && key_pos == hrp_pkg::KEY_LEN) begin
                length_found = 1'b1;
                length_reg = (value_neg && value_accum != 0) ? LEN_MAX : value_accum;
              end
            end else begin
              nx = hrp_pkg::PH_VAL;
              digit_step(b);
            end
          end
          hrp_pkg::PH_VAL_CR: if (b == hrp_pkg::CHR_LF) nx = hrp_pkg::PH_VAL_CRLF;
          hrp_pkg::PH_BODY: nx = hrp_pkg::PH_BODY;
          default: nx = hrp_pkg::PH_ERR;
        endcase
        phase = nx;
        byte_count = byte_count + 32'd1;
        if (ce) begin
          if (phase == hrp_pkg::PH_ERR) begin
            status = hrp_pkg::ST_ERROR;
          end else if (phase == hrp_pkg::PH_BODY) begin
            if (!length_found || length_reg == 0 || byte_count - body_start_pos >= length_reg) begin
              if (space_count >= hrp_pkg::SPACE_MAX) status = hrp_pkg::ST_DONE;
              else status = hrp_pkg::ST_ERROR;
            end
          end
        end
      end
      w.status = status;
      w.content_length = (phase == hrp_pkg::PH_BODY && length_found) ? length_reg : '0;
      w.uri_start = (status == hrp_pkg::ST_DONE) ? first_space_pos + 32'd1 : '0;
      parsed_q.insert(parsed_q.size(), w);
    endfunction

    function int pending();
      return parsed_q.size();
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      if (fails < 40)
        $display("[%0t] word %0d: %s got 0x%0h, expected 0x%0h", $time, words, field, got, want);
      fails++;
    endtask

    task check_word(parsed_byte_t got);
      parsed_byte_t want;
      words++;
      if (parsed_q.size() == 0) begin
        report("unexpected word, position", got.position, '0);
        return;
      end
      want = parsed_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
      if (got.position !== want.position) report("position", got.position, want.position);
      if (got.header_start !== want.header_start)
        report("header_start_mark", 32'(got.header_start), 32'(want.header_start));
      if (got.key_start !== want.key_start)
        report("key_start_mark", 32'(got.key_start), 32'(want.key_start));
      if (got.value_start !== want.value_start)
        report("value_start_mark", 32'(got.value_start), 32'(want.value_start));
      if (got.headers_end !== want.headers_end)
        report("headers_end_mark", 32'(got.headers_end), 32'(want.headers_end));
      if (got.content_length !== want.content_length)
        report("content_length", got.content_length, want.content_length);
      if (got.uri_start !== want.uri_start) report("uri_start", got.uri_start, want.uri_start);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        chunk_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic [1:0]  status_o;
  logic [31:0] position_o;
  logic        header_start_mark_o;
  logic        key_start_mark_o;
  logic        value_start_mark_o;
  logic        headers_end_mark_o;
  logic [31:0] content_length_o;
  logic [31:0] uri_start_o;

  bit quiet = 1'b0;
  bit sender_calm = 1'b0;
  int cycles = 0;
  hdr_byte_checker sb = new();

  http_request_header_parser_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .chunk_end_i        (chunk_end_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_byte_o         (out_byte_o),
    .status_o           (status_o),
    .position_o         (position_o),
    .header_start_mark_o(header_start_mark_o),
    .key_start_mark_o   (key_start_mark_o),
    .value_start_mark_o (value_start_mark_o),
    .headers_end_mark_o (headers_end_mark_o),
    .content_length_o   (content_length_o),
    .uri_start_o        (uri_start_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("FAIL http_request_header_parser_unit");
        $finish;
      end
    end
  end

  function automatic logic rand_end();
    return ($urandom_range(0, 7) == 0);
  endfunction

  function automatic logic [7:0] noncr_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == hrp_pkg::CHR_CR);
    return c;
  endfunction

  function automatic logic [7:0] key_byte();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) begin
      c = 8'(8'h61 + $urandom_range(0, 25));
      if ($urandom_range(0, 2) == 0) c = c - 8'h20;
    end else begin
      do c = 8'($urandom_range(0, 255));
      while (c == hrp_pkg::CHR_COLON || c == hrp_pkg::CHR_CR);
    end
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic ce);
    if (!quiet && !sender_calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    chunk_end_i <= ce;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_byte(b, ce);
  endtask

  task automatic send_number();
    logic [7:0] q[$];
    logic [7:0] ws_set [4];
    int         n;
    ws_set = '{hrp_pkg::CHR_SPACE, hrp_pkg::CHR_TAB, 8'h0B, 8'h0C};
    repeat ($urandom_range(0, 2)) q.insert(q.size(), ws_set[$urandom_range(0, 3)]);
    case ($urandom_range(0, 9))
      0:       q.insert(q.size(), hrp_pkg::CHR_MINUS);
      1, 2:    q.insert(q.size(), hrp_pkg::CHR_PLUS);
      default: ;
    endcase
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 2);
    repeat (n) q.insert(q.size(), 8'(hrp_pkg::CHR_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        q.insert(q.size(), ($urandom_range(0, 3) == 0) ? 8'h00 : noncr_byte());
    if (q.size() == 0) q.insert(q.size(), hrp_pkg::CHR_ZERO);
    foreach (q[i]) send_byte(q[i], rand_end());
  endtask

  task automatic send_header();
    int         kind;
    int         sub;
    int         m;
    int         z;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      for (int i = 0; i < 14; i++) begin
        c = key_char(i);
        if (c != hrp_pkg::CHR_MINUS && $urandom_range(0, 1) == 1) c = c - 8'h20;
        send_byte(c, rand_end());
      end
    end else if (kind == 1) begin
      sub = $urandom_range(0, 2);
      m = (sub == 0) ? $urandom_range(1, 13) : 14;
      z = (sub == 2) ? $urandom_range(0, 13) : 14;
      for (int i = 0; i < m; i++) send_byte((i == z) ? 8'h00 : key_char(i), rand_end());
      if (sub == 1) send_byte(key_byte(), rand_end());
    end else begin
      repeat ($urandom_range(1, 10)) send_byte(key_byte(), rand_end());
    end
    send_byte(hrp_pkg::CHR_COLON, rand_end());
    send_byte(hrp_pkg::CHR_SPACE, rand_end());
    if (kind <= 1 || $urandom_range(0, 5) == 0) send_number();
    else repeat ($urandom_range(1, 16)) send_byte(noncr_byte(), rand_end());
    send_byte(hrp_pkg::CHR_CR, rand_end());
    send_byte(hrp_pkg::CHR_LF, rand_end());
  endtask

  task automatic send_body();
    logic [31:0] need;
    need = sb.length_found ? sb.length_reg : '0;
    send_byte(hrp_pkg::CHR_CR, rand_end());
    send_byte(hrp_pkg::CHR_LF, rand_end());
    if (need <= 200) begin
      repeat (need + $urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)), rand_end());
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      repeat (50) send_byte(8'($urandom_range(0, 255)), rand_end());
    end
  endtask

  task automatic send_broken();
    logic [7:0] c;
    case ($urandom_range(0, 2))
      0: begin
        send_byte(8'h6B, rand_end());
        send_byte(hrp_pkg::CHR_COLON, rand_end());
        do c = 8'($urandom_range(0, 255)); while (c == hrp_pkg::CHR_SPACE);
        send_byte(c, rand_end());
      end
      1: begin
        send_byte(8'h6B, rand_end());
        send_byte(hrp_pkg::CHR_COLON, rand_end());
        send_byte(hrp_pkg::CHR_SPACE, rand_end());
        send_byte(8'h76, rand_end());
        send_byte(hrp_pkg::CHR_CR, rand_end());
        do c = 8'($urandom_range(0, 255)); while (c == hrp_pkg::CHR_LF);
        send_byte(c, rand_end());
      end
      default: begin
        send_byte(hrp_pkg::CHR_CR, rand_end());
        do c = 8'($urandom_range(0, 255)); while (c == hrp_pkg::CHR_LF);
        send_byte(c, rand_end());
      end
    endcase
    send_byte(8'($urandom_range(0, 255)), rand_end());
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin : receiver
    int  ticks;
    bit  held;
    ticks = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      ticks++;
      if (!quiet && !held && ticks >= 400) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end
    end
  end

  initial begin : watch
    parsed_byte_t w;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        w.out_byte       = out_byte_o;
        w.status         = status_o;
        w.position       = position_o;
        w.header_start   = header_start_mark_o;
        w.key_start      = key_start_mark_o;
        w.value_start    = value_start_mark_o;
        w.headers_end    = headers_end_mark_o;
        w.content_length = content_length_o;
        w.uri_start      = uri_start_o;
        sb.check_word(w);
      end
    end
  end

  initial begin : stimulus
    logic [8:0] directed [$];
    int         mode;
    directed = '{
      {1'b0, 8'h00}, {1'b0, 8'h47}, {1'b0, 8'hFF}, {1'b0, hrp_pkg::CHR_SPACE}, {1'b0, 8'h2F},
      {1'b0, 8'h61}, {1'b0, hrp_pkg::CHR_SPACE}, {1'b0, 8'h48}, {1'b0, 8'h31},
      {1'b1, hrp_pkg::CHR_CR}, {1'b0, hrp_pkg::CHR_LF}, {1'b0, 8'h58},
      {1'b0, hrp_pkg::CHR_MINUS}, {1'b0, 8'h51}, {1'b0, 8'h7A}, {1'b0, 8'h00},
      {1'b1, hrp_pkg::CHR_COLON}, {1'b0, hrp_pkg::CHR_SPACE}, {1'b0, 8'h41},
      {1'b0, hrp_pkg::CHR_MINUS}, {1'b0, 8'hFF}, {1'b1, hrp_pkg::CHR_CR},
      {1'b0, hrp_pkg::CHR_LF}
    };
    mode = $urandom_range(0, 3);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    while (sb.byte_count < 1600) begin
      if (sb.byte_count >= 1450) quiet = 1'b1;
      sender_calm = ($urandom_range(0, 3) == 0);
      send_header();
    end
    quiet = 1'b1;
    if (mode == 3) send_broken();
    else send_body();
    repeat (40) send_byte(8'($urandom_range(0, 255)), rand_end());
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("PASS http_request_header_parser_unit");
    end else begin
      $display("FAIL http_request_header_parser_unit");
    end
    $finish;
  end

endmodule
